[src/shared_hash_table_engine_unit_assert.svh]
// Assertion macros used by the checker file.
`ifndef SHARED_HASH_TABLE_ENGINE_UNIT_ASSERT_SVH
`define SHARED_HASH_TABLE_ENGINE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SHTE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SHTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/shte_pkg.sv]
package shte_pkg;

  localparam int OP_W    = 2;
  localparam int MAP_W   = 8;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int TAG_W   = MAP_W + KEY_W;
  localparam int ST_W    = 2;

  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_MISSING   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [MAP_W-1:0]   map_id;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [VALUE_W-1:0] value_out;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic qn;
    logic rem;
    logic rd_bucket;
    logic chk;
    logic sweep_rd;
    logic clear_wr;
    logic res_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
  } sts_t;

endpackage

[src/shte_ctrl.sv]
module shte_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_op_i,
  output logic                   in_stall_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output shte_pkg::cmd_t         cmd_o,
  input  shte_pkg::sts_t         sts_i
);
  import shte_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_QN     = 4'd2;
  localparam logic [3:0] S_REM    = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_CHK    = 4'd5;
  localparam logic [3:0] S_FL     = 4'd6;
  localparam logic [3:0] S_FL_END = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  cmd_t       cmd;

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          case (in_op_i)
            OP_PUT, OP_GET: state_d = S_QN;
            OP_FLUSH:       state_d = S_FL;
            default: begin
              cmd.res_done = 1'b1;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_QN: begin
        cmd.qn  = 1'b1;
        state_d = S_REM;
      end
      S_REM: begin
        cmd.rem = 1'b1;
        state_d = S_RD;
      end
      S_RD: begin
        cmd.rd_bucket = 1'b1;
        state_d       = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        state_d = S_DONE;
      end
      S_FL: begin
        cmd.sweep_rd = 1'b1;
        if (sts_i.cnt_last) state_d = S_FL_END;
      end
      S_FL_END: begin
        cmd.res_done = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

[src/shte_dpath.sv]
module shte_dpath #(
  parameter int NUM_BUCKETS = 1021,
  parameter int NUM_WAYS    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  shte_pkg::cmd_t      cmd_i,
  output shte_pkg::sts_t      sts_o,
  input  shte_pkg::in_word_t  in_data_i,
  output shte_pkg::out_word_t out_data_o
);
  import shte_pkg::*;

  localparam int BUCKET_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int REM_W    = BUCKET_W + 1;
  localparam logic [KEY_W-1:0]    RECIP    = KEY_W'(64'hFFFF_FFFF / NUM_BUCKETS);
  localparam logic [KEY_W-1:0]    NB_KEY   = KEY_W'(NUM_BUCKETS);
  localparam logic [REM_W-1:0]    MODULUS  = REM_W'(NUM_BUCKETS);
  localparam logic [BUCKET_W-1:0] LAST_ROW = BUCKET_W'(NUM_BUCKETS - 1);

  // bucket store: one row per bucket, read and written whole
  logic [NUM_WAYS-1:0]                valid_mem [NUM_BUCKETS];
  logic [NUM_WAYS-1:0][TAG_W-1:0]     tag_mem   [NUM_BUCKETS];
  logic [NUM_WAYS-1:0][VALUE_W-1:0]   val_mem   [NUM_BUCKETS];

  in_word_t                      item_q;
  logic [2*KEY_W-1:0]            prod_q, prod_d;
  logic [KEY_W-1:0]              qn_full;
  logic [REM_W-1:0]              qn_q, rem_raw, rem_fix;
  logic [BUCKET_W-1:0]           bucket_q, cnt_q, wb_addr_q, rd_addr;
  logic                          sweep_wb_q, rd_en, put_wr;
  logic [NUM_WAYS-1:0]           vrd_q, free_oh, flush_keep;
  logic [NUM_WAYS-1:0][TAG_W-1:0]   trd_q, put_tags;
  logic [NUM_WAYS-1:0][VALUE_W-1:0] drd_q, put_vals;
  logic [TAG_W-1:0]              tag;
  logic                          hit, free_found;
  logic [VALUE_W-1:0]            hit_val;
  out_word_t                     res_q, out_q, chk_res;

  // key mod NUM_BUCKETS: reciprocal estimate is low by at most one
  assign prod_d  = in_data_i.key * RECIP;
  assign qn_full = prod_q[2*KEY_W-1:KEY_W] * NB_KEY;
  assign rem_raw = item_q.key[REM_W-1:0] - qn_q;
  assign rem_fix = (rem_raw >= MODULUS) ? (rem_raw - MODULUS) : rem_raw;

  assign rd_en   = cmd_i.sweep_rd | cmd_i.rd_bucket;
  assign rd_addr = cmd_i.sweep_rd ? cnt_q : bucket_q;
  assign tag     = {item_q.map_id, item_q.key};

  always_comb begin
    hit        = 1'b0;
    hit_val    = '0;
    free_found = 1'b0;
    free_oh    = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (vrd_q[w] && (trd_q[w] == tag) && !hit) begin
        hit     = 1'b1;
        hit_val = drd_q[w];
      end
      if (!vrd_q[w] && !free_found) begin
        free_found = 1'b1;
        free_oh[w] = 1'b1;
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      put_tags[w]   = free_oh[w] ? tag : trd_q[w];
      put_vals[w]   = free_oh[w] ? item_q.value : drd_q[w];
      flush_keep[w] = vrd_q[w] && (trd_q[w][TAG_W-1 -: MAP_W] != item_q.map_id);
    end
  end

  assign put_wr = cmd_i.chk && (item_q.operation == OP_PUT) && !hit && free_found;

  always_comb begin
    chk_res        = '0;
    chk_res.status = ST_DONE;
    case (item_q.operation)
      OP_PUT: begin
        if (hit)              chk_res.status = ST_DUPLICATE;
        else if (!free_found) chk_res.status = ST_FULL;
      end
      OP_GET: begin
        if (hit) chk_res.value_out = hit_val;
        else     chk_res.status    = ST_MISSING;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_wr)  valid_mem[cnt_q]     <= '0;
    else if (sweep_wb_q) valid_mem[wb_addr_q] <= flush_keep;
    else if (put_wr)     valid_mem[bucket_q]  <= vrd_q | free_oh;
    if (put_wr) begin
      tag_mem[bucket_q] <= put_tags;
      val_mem[bucket_q] <= put_vals;
    end
    if (rd_en) begin
      vrd_q <= valid_mem[rd_addr];
      trd_q <= tag_mem[rd_addr];
      drd_q <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      prod_q <= prod_d;
    end
    if (cmd_i.qn)  qn_q     <= qn_full[REM_W-1:0];
    if (cmd_i.rem) bucket_q <= rem_fix[BUCKET_W-1:0];
    wb_addr_q <= cnt_q;
    if (cmd_i.res_done) begin
      res_q.status    <= ST_DONE;
      res_q.value_out <= '0;
    end else if (cmd_i.chk) begin
      res_q <= chk_res;
    end
    if (cmd_i.out_load) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      sweep_wb_q <= 1'b0;
    end else begin
      sweep_wb_q <= cmd_i.sweep_rd;
      if (cmd_i.clear_wr || cmd_i.sweep_rd) begin
        cnt_q <= sts_o.cnt_last ? '0 : cnt_q + 1'b1;
      end
    end
  end

  assign sts_o.cnt_last = (cnt_q == LAST_ROW);
  assign out_data_o     = out_q;

endmodule

[src/shared_hash_table_engine_unit.sv]
// Put and get: the word is loaded, then the reciprocal-multiply bucket stages (QN, REM) and the
// row read-modify-write (RD, CHK) run; no new word is taken until the output register is loaded.
// Flush: one bucket row per cycle over all NUM_BUCKETS rows; no new word is taken meanwhile.
// Output stalls hold a finished result while the output register is full, input stalled meanwhile.
// Reset: valid store is cleared by a pass over all NUM_BUCKETS rows, input stalled meanwhile.
module shared_hash_table_engine_unit #(
  parameter int NUM_BUCKETS = 1021,
  parameter int NUM_WAYS    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  shte_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output shte_pkg::out_word_t out_data_o
);
  import shte_pkg::*;

  cmd_t cmd;
  sts_t sts;

  shte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.operation),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  shte_dpath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .NUM_WAYS    (NUM_WAYS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

[src/shte_checker.sv]
`include "shared_hash_table_engine_unit_assert.svh"

module shte_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input shte_pkg::in_word_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input shte_pkg::out_word_t out_data_o
);
  import shte_pkg::*;

  `SHTE_ASSERT_NEXT(a_out_valid_hold, out_valid_o && out_stall_i, out_valid_o, "out valid dropped")
  `SHTE_ASSERT_NEXT(a_out_word_hold, out_valid_o && out_stall_i, $stable(out_data_o), "out word changed")
  `SHTE_ASSERT_SAME(a_value_zero, out_valid_o && (out_data_o.status != ST_DONE), out_data_o.value_out == '0, "value on failed op")
  `SHTE_ASSERT_NEXT(a_one_word, in_valid_i && !in_stall_o && (in_data_i.operation != OP_UNUSED), in_stall_o, "second word taken")

endmodule

bind shared_hash_table_engine_unit shte_checker u_shte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[verif/shared_hash_table_engine_unit_tb.sv]
module shared_hash_table_engine_unit_tb;
  import shte_pkg::*;

  localparam int NUM_BUCKETS = 1021;
  localparam int NUM_WAYS    = 4;
  localparam int SLOTS       = NUM_BUCKETS * NUM_WAYS;

  localparam int CYCLE_LIMIT      = 600000;
  localparam int DRAIN_CYCLES     = 50;
  localparam int HOLD_CYCLES      = 400;
  localparam int RANDOM_PER_PHASE = 260;
  localparam int PRESSURE_WORDS   = 100;
  localparam int MAX_KEY_MULT     = 4206626;

  class hash_table_scoreboard;
    bit               live [SLOTS];
    bit [TAG_W-1:0]   tags [SLOTS];
    bit [VALUE_W-1:0] vals [SLOTS];
    out_word_t        pending_replies [$];
    int               errors;

    function int find_way(int base, bit [TAG_W-1:0] t);
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (live[base+w] && tags[base+w] == t) return w;
      end
      return -1;
    endfunction

    function void note_request(in_word_t req);
      out_word_t      reply;
      bit [TAG_W-1:0] t;
      int             base;
      int             hit;
      reply = '0;
      t     = {req.map_id, req.key};
      base  = (req.key % NUM_BUCKETS) * NUM_WAYS;
      case (req.operation)
        OP_PUT: begin
          if (find_way(base, t) >= 0) begin
            reply.status = ST_DUPLICATE;
          end else begin
            reply.status = ST_FULL;
            for (int w = 0; w < NUM_WAYS; w++) begin
              if (!live[base+w]) begin
                live[base+w] = 1'b1;
                tags[base+w] = t;
                vals[base+w] = req.value;
                reply.status = ST_DONE;
                break;
              end
            end
          end
        end
        OP_GET: begin
          hit = find_way(base, t);
          if (hit >= 0) begin
            reply.value_out = vals[base+hit];
          end else begin
            reply.status = ST_MISSING;
          end
        end
        OP_FLUSH: begin
          for (int s = 0; s < SLOTS; s++) begin
            if (live[s] && tags[s][TAG_W-1:KEY_W] == req.map_id) live[s] = 1'b0;
          end
        end
        default: ;
      endcase
      pending_replies.push_back(reply);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_replies.size() == 0) begin
        $error("reply word with nothing outstanding: status %0d value_out %h",
               got.status, got.value_out);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.value_out !== want.value_out) begin
        $error("value_out mismatch: expected %h, actual %h", want.value_out, got.value_out);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_data_o;

  hash_table_scoreboard ledger;
  int idle_pct;
  int stall_pct;
  bit hold_request;
  int cycle_count;

  shared_hash_table_engine_unit #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .NUM_WAYS   (NUM_WAYS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("shared_hash_table_engine_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) ledger.check_result(out_data_o);
      if (in_valid_i && !in_stall_o) ledger.note_request(in_data_i);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic in_word_t make_word(logic [OP_W-1:0] op, logic [MAP_W-1:0] map_sel,
                                         logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
    in_word_t w;
    w.operation = op;
    w.map_id    = map_sel;
    w.key       = key;
    w.value     = value;
    return w;
  endfunction

  // keys mostly crowd a few buckets so duplicates and full rows come up often
  function automatic in_word_t random_word(bit allow_flush);
    in_word_t    w;
    int          r;
    int unsigned bucket;
    int unsigned mult;
    r = $urandom_range(99);
    if (allow_flush && r < 2) w.operation = OP_FLUSH;
    else if (r < 4)           w.operation = OP_UNUSED;
    else if (r < 52)          w.operation = OP_PUT;
    else                      w.operation = OP_GET;
    w.map_id = ($urandom_range(4) != 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    if ($urandom_range(4) == 0) begin
      w.key = $urandom;
    end else begin
      bucket = ($urandom_range(7) == 7) ? NUM_BUCKETS - 1 : $urandom_range(5);
      mult   = ($urandom_range(3) == 0) ? $urandom_range(MAX_KEY_MULT) : $urandom_range(2);
      w.key  = 32'(bucket + NUM_BUCKETS * mult);
    end
    w.value = $urandom;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    ledger       = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, duplicates, full row, flush holes, unused map, unused op
    send_word(make_word(OP_GET,   8'd0,   32'd0,          32'd0));
    send_word(make_word(OP_PUT,   8'd0,   32'd0,          32'd0));
    send_word(make_word(OP_PUT,   8'd0,   32'd0,          32'hFFFF_FFFF));
    send_word(make_word(OP_GET,   8'd0,   32'd0,          32'd0));
    send_word(make_word(OP_PUT,   8'd255, 32'hFFFF_FFFF,  32'hFFFF_FFFF));
    send_word(make_word(OP_GET,   8'd255, 32'hFFFF_FFFF,  32'd0));
    send_word(make_word(OP_GET,   8'd254, 32'hFFFF_FFFF,  32'd0));
    send_word(make_word(OP_PUT,   8'd1,   NUM_BUCKETS,     32'hA5A5_A5A5));
    send_word(make_word(OP_PUT,   8'd2,   2 * NUM_BUCKETS, 32'h5A5A_5A5A));
    send_word(make_word(OP_PUT,   8'd3,   32'd0,          32'h1234_5678));
    send_word(make_word(OP_PUT,   8'd4,   3 * NUM_BUCKETS, 32'h0BAD_F00D));
    send_word(make_word(OP_FLUSH, 8'd2,   32'd0,          32'd0));
    send_word(make_word(OP_GET,   8'd2,   2 * NUM_BUCKETS, 32'd0));
    send_word(make_word(OP_GET,   8'd3,   32'd0,          32'd0));
    send_word(make_word(OP_PUT,   8'd3,   32'd0,          32'd7));
    send_word(make_word(OP_PUT,   8'd5,   4 * NUM_BUCKETS, 32'hCAFE_0001));
    send_word(make_word(OP_GET,   8'd5,   4 * NUM_BUCKETS, 32'd0));
    send_word(make_word(OP_FLUSH, 8'd77,  32'hFFFF_FFFF,  32'hFFFF_FFFF));
    send_word(make_word(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF,  32'hFFFF_FFFF));
    send_word(make_word(OP_GET,   8'd1,   NUM_BUCKETS,     32'd0));

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      repeat (RANDOM_PER_PHASE) send_word(random_word(1'b1));
    end

    // back-pressure: receiver holds off while words keep coming
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 1'b1;
    repeat (PRESSURE_WORDS) send_word(random_word(1'b0));

    in_valid_i <= 1'b0;
    while (ledger.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("shared_hash_table_engine_unit verification clean");
    end else begin
      $display("shared_hash_table_engine_unit verification failed");
    end
    $finish;
  end

endmodule
